// ===== rtl/line_follow_pid_steering_top_defines.svh =====
// Assertion macros for the line-follow PID steering block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef LINE_FOLLOW_PID_STEERING_TOP_DEFINES_SVH
`define LINE_FOLLOW_PID_STEERING_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define LFPS_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LFPS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LFPS_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg)
`define LFPS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg)

`endif

`endif

// ===== rtl/lfps_pkg.sv =====
// Shared types and constants of the line-follow PID steering block.
// No dependencies; used by lfps_div and line_follow_pid_steering_top.
`timescale 1ns / 1ps

package lfps_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_MAX_CORR   = 3'd3,
    REG_BASE_SPEED = 3'd4,
    REG_INTERVAL   = 3'd5
  } cfg_reg_t;

  // Datapath widths, Q16.16 values kept only as wide as their ranges need.
  localparam int ERR_W   = 18;  // error: 0 or +-1.2
  localparam int DIFF_W  = 19;  // error minus previous error
  localparam int INTEG_W = 23;  // integral, limited to +-50
  localparam int DERIV_W = 29;  // derivative
  localparam int GAIN_W  = 16;
  localparam int DIGIT_W = 4;
  localparam int VAL_W   = 41;  // widest operand after its last digit shift
  localparam int ACC_W   = 46;  // sum of the three products, Q24.24
  localparam int CORR_W  = 25;  // limited correction, Q16.16
  localparam int MAC_STEPS = 12;
  localparam int MAC_CNT_W = 4;

  // Serial divider.
  localparam int DIV_NUM_W = 34;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = 6;

  localparam int DT_CAP_W = 17;

  localparam logic [DT_CAP_W-1:0]  ERR_MAG     = 17'd78643;
  localparam int                   INTEG_LIMIT = 3276800;
  localparam logic [DIV_DEN_W-1:0] FALLBACK_DT = 32'd20;
  localparam logic [DIV_DEN_W-1:0] MS_PER_S    = 32'd1000;

  typedef enum logic [2:0] {
    LS_INLINE    = 3'd0,
    LS_CROSS     = 3'd1,
    LS_TILT_L    = 3'd2,
    LS_TILT_R    = 3'd3,
    LS_REAR_STOP = 3'd4
  } line_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD_I,
    ST_DIV_I,
    ST_LOAD_D,
    ST_DIV_D,
    ST_MAC,
    ST_FINISH,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/lfps_div.sv =====
// Bit-serial restoring divider for unsigned operands, one quotient bit per cycle.
// Depends on lfps_pkg for its widths and status struct.
`timescale 1ns / 1ps

module lfps_div import lfps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_NUM_W-1:0] quot,
  output div_stat_t            stat
);

  logic [DIV_NUM_W-1:0] q_sh;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   trial_sub;
  logic                 fits;

  // The numerator shifts out of the top of q_sh while quotient bits enter below.
  assign trial     = {rem, q_sh[DIV_NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= '0;
      q_sh  <= num;
      den_r <= den;
      rem   <= '0;
    end else if (busy) begin
      q_sh <= {q_sh[DIV_NUM_W-2:0], fits};
      rem  <= fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      cnt  <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign quot      = q_sh;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/line_follow_pid_steering_top.sv =====
// Line-follow PID steering: one tick in, zero or one speed command out.
// A PID update runs two 34-step bit-serial divisions before its result is registered, and the
// next tick is taken once that result has been registered.
// Skipped ticks (too early, inline, after halt) give no command; rear stop gives a halt.
// Synchronous active-high reset restores the register defaults and clears the PID state.
// Depends on lfps_pkg, lfps_div and line_follow_pid_steering_top_defines.svh.
`timescale 1ns / 1ps

`include "line_follow_pid_steering_top_defines.svh"

module line_follow_pid_steering_top import lfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // ticks
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           now_ms,
  input  logic                  sens_rl,
  input  logic                  sens_fl,
  input  logic                  sens_fr,
  input  logic                  sens_rr,
  // speed commands
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            speed_l,
  output logic [7:0]            speed_r,
  output logic signed [8:0]     correction,
  output logic [2:0]            line_state,
  output logic                  halted
);

  localparam int ISUM_W = 26;
  localparam int SPD_W  = 26;
  localparam logic signed [ISUM_W-1:0]  ISUM_HI  = ISUM_W'(INTEG_LIMIT);
  localparam logic signed [INTEG_W-1:0] INTEG_HI = INTEG_W'(INTEG_LIMIT);
  localparam logic [DT_CAP_W-1:0]       DT_CAP   = '1;

  // Configuration registers.
  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;
  logic [7:0]        max_correction;
  logic [7:0]        base_speed;
  logic [9:0]        update_interval_ms;

  // Controller state.
  st_t                       state;
  st_t                       state_next;
  line_state_t               line_class;
  logic [31:0]               last_upd_ms;
  logic signed [ERR_W-1:0]   previous_error;
  logic signed [INTEG_W-1:0] integral_sum;
  logic                      stop_latch;

  // Working registers of one update.
  logic [31:0]               now_r;
  logic                      rl_r;
  logic                      fl_r;
  logic                      fr_r;
  logic                      rr_r;
  logic [DIV_DEN_W-1:0]      dt_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [DERIV_W-1:0] deriv_r;
  logic                      res_halt;
  logic signed [ACC_W-1:0]   acc;
  logic [GAIN_W-1:0]         gain_sh;
  logic signed [VAL_W-1:0]   val_sh;
  logic [MAC_CNT_W-1:0]      mac_cnt;
  logic signed [CORR_W-1:0]  corr_r;

  // Divider interface.
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quot;
  div_stat_t            div_stat;

  // Combinational helpers.
  logic [31:0]               elapsed;
  logic                      too_early;
  line_state_t               cls;
  logic signed [ERR_W-1:0]   cls_err;
  logic [DT_CAP_W-1:0]       dt_cap;
  logic [DIV_NUM_W-1:0]      num_i;
  logic signed [DIFF_W-1:0]  err_diff;
  logic [ERR_W-1:0]          diff_mag;
  logic [DIV_NUM_W-1:0]      num_d;
  logic signed [ISUM_W-1:0]  int_term;
  logic signed [ISUM_W-1:0]  int_sum;
  logic signed [INTEG_W-1:0] int_clamped;
  logic signed [DERIV_W-1:0] deriv_val;
  logic signed [ACC_W-1:0]   mac_prod;
  logic signed [ACC_W-1:0]   rnd;
  logic signed [ACC_W-1:0]   sum_adj;
  logic signed [ACC_W-1:0]   sum_q;
  logic signed [ACC_W-1:0]   lim_x;
  logic signed [CORR_W-1:0]  corr_val;
  logic signed [SPD_W-1:0]   base_x;
  logic signed [SPD_W-1:0]   corr_x;
  logic signed [SPD_W-1:0]   left_raw;
  logic signed [SPD_W-1:0]   right_raw;
  logic [7:0]                left_sat;
  logic [7:0]                right_sat;
  logic [CORR_W-1:0]         corr_mag;
  logic [8:0]                corr_int;
  logic                      out_free;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p             <= 16'd256;
      gain_i             <= '0;
      gain_d             <= '0;
      max_correction     <= 8'd100;
      base_speed         <= 8'd150;
      update_interval_ms <= 10'd20;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GAIN_P:     gain_p             <= cfg_wdata;
        REG_GAIN_I:     gain_i             <= cfg_wdata;
        REG_GAIN_D:     gain_d             <= cfg_wdata;
        REG_MAX_CORR:   max_correction     <= cfg_wdata[7:0];
        REG_BASE_SPEED: base_speed         <= cfg_wdata[7:0];
        REG_INTERVAL:   update_interval_ms <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Classification and divider operands
  // ---------------------------------------------------------------------------
  assign elapsed   = now_r - last_upd_ms;
  assign too_early = (elapsed < {22'd0, update_interval_ms});

  always_comb begin
    if (fl_r && fr_r) begin
      cls = LS_CROSS;
    end else if (fl_r) begin
      cls = LS_TILT_L;
    end else if (fr_r) begin
      cls = LS_TILT_R;
    end else begin
      cls = LS_INLINE;
    end
  end

  always_comb begin
    case (cls)
      LS_TILT_L: cls_err = -$signed({1'b0, ERR_MAG});
      LS_TILT_R: cls_err = $signed({1'b0, ERR_MAG});
      default:   cls_err = '0;
    endcase
  end

  // Any dt past the cap drives the integral into its limit anyway.
  assign dt_cap = (dt_r > DIV_DEN_W'(DT_CAP)) ? DT_CAP : dt_r[DT_CAP_W-1:0];
  assign num_i  = (err_r == '0) ? '0 : DIV_NUM_W'(ERR_MAG) * DIV_NUM_W'(dt_cap);

  assign err_diff = {err_r[ERR_W-1], err_r} - {previous_error[ERR_W-1], previous_error};
  always_comb begin
    if (err_diff[DIFF_W-1]) begin
      diff_mag = ERR_W'(-err_diff);
    end else begin
      diff_mag = err_diff[ERR_W-1:0];
    end
  end
  assign num_d = DIV_NUM_W'(diff_mag) * DIV_NUM_W'(MS_PER_S);

  // Integral: quotient magnitude stays below 2^24 because dt is capped.
  always_comb begin
    if (err_r[ERR_W-1]) begin
      int_term = -$signed({2'b00, div_quot[23:0]});
    end else begin
      int_term = $signed({2'b00, div_quot[23:0]});
    end
    int_sum = {{(ISUM_W-INTEG_W){integral_sum[INTEG_W-1]}}, integral_sum} + int_term;
    if (int_sum > ISUM_HI) begin
      int_clamped = INTEG_HI;
    end else if (int_sum < -ISUM_HI) begin
      int_clamped = -INTEG_HI;
    end else begin
      int_clamped = int_sum[INTEG_W-1:0];
    end
  end

  always_comb begin
    if (err_diff[DIFF_W-1]) begin
      deriv_val = -$signed({1'b0, div_quot[DERIV_W-2:0]});
    end else begin
      deriv_val = $signed({1'b0, div_quot[DERIV_W-2:0]});
    end
  end

  lfps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // ---------------------------------------------------------------------------
  // Digit-serial multiply-accumulate: one 4-bit gain digit per cycle
  // ---------------------------------------------------------------------------
  assign mac_prod = $signed({1'b0, gain_sh[DIGIT_W-1:0]}) * val_sh;

  // Q24.24 to Q16.16 with truncation toward zero, then the correction limit.
  assign rnd     = {{(ACC_W-8){1'b0}}, {8{acc[ACC_W-1]}}};
  assign sum_adj = acc + rnd;
  assign sum_q   = sum_adj >>> 8;
  assign lim_x   = $signed({{(ACC_W-24){1'b0}}, max_correction, 16'h0000});

  always_comb begin
    if (sum_q > lim_x) begin
      corr_val = lim_x[CORR_W-1:0];
    end else if (sum_q < -lim_x) begin
      corr_val = CORR_W'(-lim_x);
    end else begin
      corr_val = sum_q[CORR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Wheel speeds and integer correction
  // ---------------------------------------------------------------------------
  assign base_x    = $signed({2'b00, base_speed, 16'h0000});
  assign corr_x    = {{(SPD_W-CORR_W){corr_r[CORR_W-1]}}, corr_r};
  assign left_raw  = base_x - corr_x;
  assign right_raw = base_x + corr_x;

  always_comb begin
    if (left_raw[SPD_W-1]) begin
      left_sat = '0;
    end else if (left_raw[24]) begin
      left_sat = 8'hFF;
    end else begin
      left_sat = left_raw[23:16];
    end
    if (right_raw[SPD_W-1]) begin
      right_sat = '0;
    end else if (right_raw[24]) begin
      right_sat = 8'hFF;
    end else begin
      right_sat = right_raw[23:16];
    end
  end

  always_comb begin
    if (corr_r[CORR_W-1]) begin
      corr_mag = CORR_W'(-corr_r);
      corr_int = 9'(-$signed({1'b0, corr_mag[23:16]}));
    end else begin
      corr_mag = corr_r;
      corr_int = {1'b0, corr_mag[23:16]};
    end
  end

  assign out_free = !out_valid || out_ready;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stop_latch || too_early) begin
          state_next = ST_IDLE;
        end else if (rl_r || rr_r) begin
          state_next = ST_DONE;
        end else if (cls == LS_INLINE) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_LOAD_I;
        end
      end
      ST_LOAD_I: state_next = ST_DIV_I;
      ST_DIV_I: begin
        if (div_stat.done) begin
          state_next = ST_LOAD_D;
        end
      end
      ST_LOAD_D: state_next = ST_DIV_D;
      ST_DIV_D: begin
        if (div_stat.done) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_cnt == MAC_CNT_W'(MAC_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_num   = num_i;
    div_den   = MS_PER_S;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_LOAD_I: div_start = 1'b1;
      ST_LOAD_D: begin
        div_start = 1'b1;
        div_num   = num_d;
        div_den   = dt_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Controller state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_class     <= LS_INLINE;
      last_upd_ms    <= '0;
      previous_error <= '0;
      integral_sum   <= '0;
      stop_latch     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            now_r <= now_ms;
            rl_r  <= sens_rl;
            fl_r  <= sens_fl;
            fr_r  <= sens_fr;
            rr_r  <= sens_rr;
          end
        end
        ST_CHECK: begin
          if (!stop_latch && !too_early) begin
            if (rl_r || rr_r) begin
              line_class <= LS_REAR_STOP;
              stop_latch <= 1'b1;
              res_halt   <= 1'b1;
            end else begin
              line_class <= cls;
              res_halt   <= 1'b0;
              err_r      <= cls_err;
              dt_r       <= (elapsed == '0) ? FALLBACK_DT : elapsed;
            end
          end
        end
        ST_DIV_I: begin
          if (div_stat.done) begin
            integ_r <= int_clamped;
          end
        end
        ST_DIV_D: begin
          if (div_stat.done) begin
            deriv_r <= deriv_val;
            acc     <= '0;
            mac_cnt <= '0;
            gain_sh <= gain_p;
            val_sh  <= {{(VAL_W-ERR_W){err_r[ERR_W-1]}}, err_r};
          end
        end
        ST_MAC: begin
          acc     <= acc + mac_prod;
          mac_cnt <= mac_cnt + 1'b1;
          if (mac_cnt[1:0] == 2'd3) begin
            // Next product term: integral after proportional, derivative after that.
            if (mac_cnt[3:2] == 2'd0) begin
              gain_sh <= gain_i;
              val_sh  <= {{(VAL_W-INTEG_W){integ_r[INTEG_W-1]}}, integ_r};
            end else begin
              gain_sh <= gain_d;
              val_sh  <= {{(VAL_W-DERIV_W){deriv_r[DERIV_W-1]}}, deriv_r};
            end
          end else begin
            gain_sh <= gain_sh >> DIGIT_W;
            val_sh  <= val_sh <<< DIGIT_W;
          end
        end
        ST_FINISH: begin
          corr_r         <= corr_val;
          integral_sum   <= integ_r;
          previous_error <= err_r;
          last_upd_ms    <= now_r;
        end
        default: ;
      endcase
    end
  end

  // Output register: holds a finished result while the next tick is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
      if (res_halt) begin
        speed_l    <= '0;
        speed_r    <= '0;
        correction <= '0;
        halted     <= 1'b1;
      end else begin
        speed_l    <= left_sat;
        speed_r    <= right_sat;
        correction <= $signed(corr_int);
        halted     <= 1'b0;
      end
      line_state <= line_class;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LFPS_ASSERT_IMPL(a_halt_payload, clk, rst, out_valid && halted, speed_l == 8'd0 && speed_r == 8'd0 && line_state == LS_REAR_STOP, "halt result carries nonzero speed or wrong class")
  `LFPS_ASSERT_NEXT(a_latch_sticks, clk, rst, stop_latch, stop_latch, "stop latch cleared without reset")
  `LFPS_ASSERT_IMPL(a_corr_limit, clk, rst, out_valid && !halted, correction <= $signed({1'b0, max_correction}) && correction >= -$signed({1'b0, max_correction}), "correction exceeds its limit")
  `LFPS_ASSERT_IMPL(a_integ_limit, clk, rst, 1'b1, integral_sum <= INTEG_HI && integral_sum >= -INTEG_HI, "integral outside its clamp")
  `LFPS_ASSERT_IMPL(a_div_owner, clk, rst, div_stat.busy || div_stat.done, state == ST_DIV_I || state == ST_DIV_D, "divider active outside a divide step")

endmodule
